// ----- sv/rmtp_pkg.sv -----
// rmtp_pkg: shared types and constants for the running median block
// used by rmtp_cell and running_median_time_past; no dependencies
`timescale 1ns / 1ps

package rmtp_pkg;

	localparam int TIME_W = 32;
	localparam int FILL_W = 4;
	localparam int OUT_W  = 40;

	// what one cell shows its neighbors in the sorted chain
	typedef struct packed {
		logic [TIME_W-1:0] value;
		logic              valid;
		logic              cmp;        // valid and value <= incoming time
		logic              del_chain;  // oldest entry sits here or below
	} rmtp_link_t;

endpackage

// ----- sv/rmtp_cell.sv -----
// rmtp_cell: one slot of the sorted timestamp chain with its age
// depends on rmtp_pkg
`timescale 1ns / 1ps

module rmtp_cell #(
	parameter int WINDOW = 11,
	parameter int AGE_W  = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ins,
	input  logic [rmtp_pkg::TIME_W-1:0] new_value,
	input  rmtp_pkg::rmtp_link_t      lo_link,
	input  logic [AGE_W-1:0]          lo_age,
	input  rmtp_pkg::rmtp_link_t      up_link,
	input  logic [AGE_W-1:0]          up_age,
	output rmtp_pkg::rmtp_link_t      link,
	output logic [AGE_W-1:0]          age
);

	logic [rmtp_pkg::TIME_W-1:0] value_q;
	logic                        valid_q;
	logic [AGE_W-1:0]            age_q;
	logic                        del;
	logic                        at_or_below;
	logic                        take_up;
	logic                        take_down;
	logic                        put_new;

	assign link.value     = value_q;
	assign link.valid     = valid_q;
	assign link.cmp       = valid_q && (value_q <= new_value);
	assign del            = valid_q && (age_q == AGE_W'(WINDOW - 1));
	assign at_or_below    = del || lo_link.del_chain;
	assign link.del_chain = at_or_below;
	assign age            = age_q;

	// removal of the oldest closes the gap from above, insertion opens one
	assign take_up   = at_or_below && up_link.cmp;
	assign put_new   = (at_or_below && link.cmp && !up_link.cmp)
		|| (!lo_link.del_chain && !link.cmp && lo_link.cmp);
	assign take_down = !lo_link.del_chain && !lo_link.cmp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (ins) begin
			if (put_new) begin
				valid_q <= 1'b1;
				age_q   <= '0;
			end else if (take_up) begin
				valid_q <= up_link.valid;
				age_q   <= up_age + AGE_W'(1);
			end else if (take_down) begin
				valid_q <= lo_link.valid;
				age_q   <= lo_age + AGE_W'(1);
			end else begin
				age_q   <= age_q + AGE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			if (put_new) begin
				value_q <= new_value;
			end else if (take_up) begin
				value_q <= up_link.value;
			end else if (take_down) begin
				value_q <= lo_link.value;
			end
		end
	end

endmodule

// ----- sv/running_median_time_past.sv -----
// running_median_time_past: top level of the sliding-window timestamp median
// depends on rmtp_pkg and rmtp_cell
`timescale 1ns / 1ps

// The block takes one unsigned 32-bit block timestamp per request and answers
// each with one result: the median of the last WINDOW timestamps (all of them
// while fewer have arrived), i.e. the sorted element at index count/2, plus
// the number of timestamps now held. The window lives in a row of WINDOW cells
// kept in ascending order; every cell tags its entry with an age. On a request
// each cell decides from its own compare and its neighbors' flags whether to
// keep its entry, take the neighbor above (the oldest entry left the chain
// below it), take the neighbor below (the new timestamp went in below it) or
// load the new timestamp, so the oldest entry drops out and the new one is
// placed on the same clock edge. The next clock reads the cell at count/2 into the
// output register. One request is in flight at a time: the result is valid once
// it is in the output register, and a new request is accepted only after the
// previous one has reached it and its result is leaving or gone. No clearing pass
// is needed after reset; empty cells are simply marked invalid.

module running_median_time_past #(
	parameter int WINDOW = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] block_time
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // [31:0] median_time, [35:32] window_fill, [39:36] zero
);

	localparam int AGE_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int IDX_W  = AGE_W;
	localparam int CNT_W  = $clog2(WINDOW + 1);

	// chain links: index i is what cell i shows; the ends are fixed
	rmtp_pkg::rmtp_link_t links [WINDOW];
	logic [AGE_W-1:0]     ages  [WINDOW];

	logic                 in_acc;
	logic                 out_acc;
	logic                 pend_q;
	logic                 m_valid_q;
	logic [CNT_W-1:0]     fill_q;
	logic [CNT_W-1:0]     half;
	logic [IDX_W-1:0]     med_idx;
	logic [rmtp_pkg::TIME_W-1:0] med_time_q;
	logic [rmtp_pkg::FILL_W-1:0] fill_out_q;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_acc       = m_valid_q && m_axis_tready;
	// accept only with nothing in flight and the output free or draining now
	assign s_axis_tready = !pend_q && (!m_valid_q || m_axis_tready);

	// sorted cell row
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		rmtp_pkg::rmtp_link_t lo_l;
		rmtp_pkg::rmtp_link_t up_l;
		logic [AGE_W-1:0]     lo_a;
		logic [AGE_W-1:0]     up_a;

		if (i == 0) begin : g_bottom
			// below the first cell: everything compares low, nothing deleted
			assign lo_l = '{value: '0, valid: 1'b0, cmp: 1'b1, del_chain: 1'b0};
			assign lo_a = '0;
		end else begin : g_lower
			assign lo_l = links[i-1];
			assign lo_a = ages[i-1];
		end

		if (i == WINDOW - 1) begin : g_top
			assign up_l = '{value: '0, valid: 1'b0, cmp: 1'b0, del_chain: 1'b0};
			assign up_a = '0;
		end else begin : g_upper
			assign up_l = links[i+1];
			assign up_a = ages[i+1];
		end

		rmtp_cell #(
			.WINDOW(WINDOW),
			.AGE_W (AGE_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ins      (in_acc),
			.new_value(s_axis_tdata),
			.lo_link  (lo_l),
			.lo_age   (lo_a),
			.up_link  (up_l),
			.up_age   (up_a),
			.link     (links[i]),
			.age      (ages[i])
		);
	end

	// fill count saturates at the window length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_acc && (fill_q != CNT_W'(WINDOW))) begin
			fill_q <= fill_q + CNT_W'(1);
		end
	end

	// request in the chain this cycle, result loads next edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			pend_q <= in_acc;
			if (pend_q) begin
				m_valid_q <= 1'b1;
			end else if (out_acc) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// median sits at sorted index count/2
	assign half    = fill_q >> 1;
	assign med_idx = half[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (pend_q) begin
			med_time_q <= links[med_idx].value;
			fill_out_q <= rmtp_pkg::FILL_W'(fill_q);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0000, fill_out_q, med_time_q};

endmodule

// ----- sv/rmtp_checker.sv -----
// rmtp_checker: port-level assertions for running_median_time_past
// bound to the top level below; depends on nothing else
`timescale 1ns / 1ps

module rmtp_checker #(
	parameter int WINDOW = 11
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	logic s_acc;

	assign s_acc = s_axis_tvalid && s_axis_tready;

	// a stalled result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one request in flight: no second accept right after one
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_axis_tready)
		else $error("request accepted while previous one in flight");

	// every request is followed by a valid result once it has passed the cell row and the output register
	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |-> ##2 m_axis_tvalid)
		else $error("result missing after request");

	// a result reports a window fill between one and WINDOW; not checked for WINDOW above 15
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (WINDOW > 15) ||
			((m_axis_tdata[35:32] != 4'd0) && (m_axis_tdata[35:32] <= 4'(WINDOW))))
		else $error("window fill out of range");

endmodule

bind running_median_time_past rmtp_checker #(
	.WINDOW(WINDOW)
) u_rmtp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
